/* sv/bidat_pkg.sv */
package bidat_pkg;

    // Default table geometry
    localparam int FIRST_ID_DEF   = 5;
    localparam int TABLE_SIZE_DEF = 11;

    // Request opcodes
    localparam logic [2:0] OP_ASSIGN      = 3'd0;
    localparam logic [2:0] OP_RELEASE     = 3'd1;
    localparam logic [2:0] OP_SET_STATUS  = 3'd2;
    localparam logic [2:0] OP_GET_STATUS  = 3'd3;
    localparam logic [2:0] OP_FIND_STATUS = 3'd4;

    // Entry status codes
    localparam logic [2:0] STAT_INACTIVE  = 3'd0;
    localparam logic [2:0] STAT_LIMIT     = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic       used;
        logic [2:0] status;
    } entry_t;

endpackage

/* sv/bearer_id_allocation_table_core.sv */
// Channel   Handshake          Payload
// request   start / busy       opcode, bearer_id, new_status
// result    done (strobe)      result_id, success, status_read, in_use, reserved_id
//
// Get, set, release and assign by identity: one memory read, one modify/write
// step in the EXEC state; busy only in that state, then a registered result strobe.
// Next-fit assign and find: one entry memory read per cycle, busy until a hit or
// the last of SLOT_CNT slots, result strobe in the cycle after the scan ends.
// Unknown opcodes: result strobe on the next cycle, busy stays low.
// Reset clears the entry table (per-entry valid bits), the cursor and the strobe.
// The result strobe lasts one cycle; the receiver cannot stall it.
module bearer_id_allocation_table_core #(
    parameter int FIRST_ID   = bidat_pkg::FIRST_ID_DEF,
    parameter int TABLE_SIZE = bidat_pkg::TABLE_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] opcode,
    input  logic [3:0] bearer_id,
    input  logic [2:0] new_status,
    output logic       done,
    output logic [3:0] result_id,
    output logic       success,
    output logic [2:0] status_read,
    output logic       in_use,
    output logic       reserved_id
);

    localparam int SLOT_CNT = (FIRST_ID + TABLE_SIZE > 16) ? (16 - FIRST_ID) : TABLE_SIZE;
    localparam int SW       = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;
    localparam int CW       = $clog2(SLOT_CNT + 1);
    localparam logic [4:0]    FIRST_W = 5'(FIRST_ID);
    localparam logic [4:0]    LIMIT_W = 5'(FIRST_ID + SLOT_CNT);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_CNT - 1);
    localparam logic [CW-1:0] CUR_END   = CW'(SLOT_CNT);

    bidat_pkg::state_t state_reg, state_next;

    logic [2:0]    op_reg;
    logic [3:0]    id_reg;
    logic [2:0]    st_reg;
    logic          have_reg;
    logic [SW-1:0] rd_slot_reg, rd_slot_next;
    logic [SW-1:0] scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0] cursor_reg, cursor_next;

    logic          done_reg, done_next;
    logic [3:0]    result_id_reg, result_id_next;
    logic          success_reg, success_next;
    logic [2:0]    status_read_reg, status_read_next;
    logic          in_use_reg, in_use_next;
    logic          reserved_id_reg, reserved_id_next;

    logic          accept;
    logic          in_have;
    logic [SW-1:0] in_slot;
    logic [SW-1:0] start_slot;
    logic [SW-1:0] wrap_slot;
    logic          search_op;
    logic          scan_hit;
    logic          scan_last;
    logic [3:0]    slot_id;

    logic              rd_en;
    logic [SW-1:0]     rd_addr;
    bidat_pkg::entry_t rd_data;
    logic              wr_en;
    bidat_pkg::entry_t wr_data;

    bidat_store #(
        .DEPTH (SLOT_CNT),
        .AW    (SW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (rd_slot_reg),
        .wr_data (wr_data)
    );

    // Decode the incoming identity into a slot
    assign accept     = start && (state_reg == bidat_pkg::S_IDLE);
    assign in_have    = ({1'b0, bearer_id} >= FIRST_W) && ({1'b0, bearer_id} < LIMIT_W);
    assign in_slot    = SW'(5'({1'b0, bearer_id}) - FIRST_W);
    assign start_slot = (cursor_reg >= CUR_END) ? '0 : SW'(cursor_reg);
    assign wrap_slot  = (rd_slot_reg == LAST_SLOT) ? '0 : SW'(32'(rd_slot_reg) + 1);
    assign slot_id    = 4'(5'(rd_slot_reg) + FIRST_W);
    assign search_op  = (op_reg == bidat_pkg::OP_ASSIGN);

    // Scan test on the entry that arrived this cycle
    assign scan_last = (scan_cnt_reg == LAST_SLOT);
    assign scan_hit  = search_op ? !rd_data.used
                                 : (rd_data.used && (rd_data.status == st_reg));

    // Issue memory reads
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (accept)
        begin
            rd_en = 1'b1;
            if ((opcode == bidat_pkg::OP_ASSIGN) && (bearer_id == 4'd0))
            begin
                rd_addr = start_slot;
            end
            else if (opcode == bidat_pkg::OP_FIND_STATUS)
            begin
                rd_addr = '0;
            end
            else if (in_have)
            begin
                rd_addr = in_slot;
            end
        end
        else if ((state_reg == bidat_pkg::S_SCAN) && !scan_hit && !scan_last)
        begin
            rd_en   = 1'b1;
            rd_addr = wrap_slot;
        end
    end

    assign rd_slot_next  = rd_en ? rd_addr : rd_slot_reg;
    assign scan_cnt_next = accept ? '0 : SW'(32'(scan_cnt_reg) + 1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bidat_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (((opcode == bidat_pkg::OP_ASSIGN) && (bearer_id == 4'd0)) ||
                        (opcode == bidat_pkg::OP_FIND_STATUS))
                    begin
                        state_next = bidat_pkg::S_SCAN;
                    end
                    else if ((opcode == bidat_pkg::OP_ASSIGN) ||
                             (opcode == bidat_pkg::OP_RELEASE) ||
                             (opcode == bidat_pkg::OP_SET_STATUS) ||
                             (opcode == bidat_pkg::OP_GET_STATUS))
                    begin
                        state_next = bidat_pkg::S_EXEC;
                    end
                end
            end
            bidat_pkg::S_EXEC:
            begin
                state_next = bidat_pkg::S_IDLE;
            end
            bidat_pkg::S_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = bidat_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bidat_pkg::S_IDLE;
            end
        endcase
    end

    // Modify, write back and form the result
    always_comb
    begin
        wr_en            = 1'b0;
        wr_data          = '0;
        cursor_next      = cursor_reg;
        done_next        = 1'b0;
        result_id_next   = result_id_reg;
        success_next     = success_reg;
        status_read_next = status_read_reg;
        in_use_next      = in_use_reg;
        reserved_id_next = reserved_id_reg;

        unique case (state_reg)
            bidat_pkg::S_IDLE:
            begin
                // Unknown opcodes answer at once with all fields clear
                if (accept && (opcode > bidat_pkg::OP_FIND_STATUS))
                begin
                    done_next        = 1'b1;
                    result_id_next   = '0;
                    success_next     = 1'b0;
                    status_read_next = '0;
                    in_use_next      = 1'b0;
                    reserved_id_next = 1'b0;
                end
            end
            bidat_pkg::S_EXEC:
            begin
                done_next        = 1'b1;
                result_id_next   = '0;
                success_next     = 1'b0;
                status_read_next = '0;
                in_use_next      = 1'b0;
                reserved_id_next = 1'b0;
                unique case (op_reg)
                    bidat_pkg::OP_ASSIGN:
                    begin
                        if (have_reg && !rd_data.used)
                        begin
                            wr_en          = 1'b1;
                            wr_data.used   = 1'b1;
                            wr_data.status = bidat_pkg::STAT_INACTIVE;
                            cursor_next    = CW'(32'(rd_slot_reg) + 1);
                            result_id_next = slot_id;
                            success_next   = 1'b1;
                        end
                    end
                    bidat_pkg::OP_RELEASE:
                    begin
                        if (have_reg && rd_data.used &&
                            (rd_data.status == bidat_pkg::STAT_INACTIVE))
                        begin
                            wr_en        = 1'b1;
                            success_next = 1'b1;
                        end
                    end
                    bidat_pkg::OP_SET_STATUS:
                    begin
                        if (have_reg && rd_data.used && (st_reg < bidat_pkg::STAT_LIMIT) &&
                            (st_reg != rd_data.status))
                        begin
                            wr_en          = 1'b1;
                            wr_data.used   = 1'b1;
                            wr_data.status = st_reg;
                            success_next   = 1'b1;
                        end
                    end
                    bidat_pkg::OP_GET_STATUS:
                    begin
                        success_next     = 1'b1;
                        in_use_next      = have_reg && rd_data.used;
                        status_read_next = (have_reg && rd_data.used) ? rd_data.status : '0;
                        reserved_id_next = (id_reg != 4'd0) && ({1'b0, id_reg} < FIRST_W);
                    end
                    default:
                    begin
                        success_next = 1'b0;
                    end
                endcase
            end
            bidat_pkg::S_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    done_next        = 1'b1;
                    result_id_next   = '0;
                    success_next     = 1'b0;
                    status_read_next = '0;
                    in_use_next      = 1'b0;
                    reserved_id_next = 1'b0;
                    if (scan_hit)
                    begin
                        result_id_next = slot_id;
                        success_next   = 1'b1;
                        if (search_op)
                        begin
                            wr_en          = 1'b1;
                            wr_data.used   = 1'b1;
                            wr_data.status = bidat_pkg::STAT_INACTIVE;
                            cursor_next    = CW'(32'(rd_slot_reg) + 1);
                        end
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bidat_pkg::S_IDLE;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            done_reg   <= done_next;
        end
    end

    // Latch the request and advance the scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            id_reg   <= bearer_id;
            st_reg   <= new_status;
            have_reg <= in_have;
        end
        rd_slot_reg     <= rd_slot_next;
        scan_cnt_reg    <= scan_cnt_next;
        result_id_reg   <= result_id_next;
        success_reg     <= success_next;
        status_read_reg <= status_read_next;
        in_use_reg      <= in_use_next;
        reserved_id_reg <= reserved_id_next;
    end

    assign busy        = (state_reg != bidat_pkg::S_IDLE);
    assign done        = done_reg;
    assign result_id   = result_id_reg;
    assign success     = success_reg;
    assign status_read = status_read_reg;
    assign in_use      = in_use_reg;
    assign reserved_id = reserved_id_reg;

endmodule

/* sv/bidat_store.sv */
module bidat_store #(
    parameter int DEPTH = 11,
    parameter int AW    = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output bidat_pkg::entry_t     rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  bidat_pkg::entry_t     wr_data
);

    bidat_pkg::entry_t mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    bidat_pkg::entry_t rd_data_reg;
    logic              rd_vld_reg;

    // Write the entry array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Mark entries written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Register the read data and its valid bit
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // Unwritten entries read as free and inactive
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* sv/bidat_checker.sv */
module bidat_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] result_id,
    input logic       success,
    input logic [2:0] status_read,
    input logic       in_use
);

    // A result appears only once the sequencer is free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Every transfer either starts work or answers on the next cycle
    a_start_reacts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request transfer had no effect");

    // Finishing work always delivers a result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // Failed requests report no identity
    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !success) |-> (result_id == 4'd0))
        else $error("identity reported on failure");

    // A nonzero status is only read from an assigned entry
    a_status_used: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status_read != 3'd0)) |-> in_use)
        else $error("status read from a free entry");

endmodule

bind bearer_id_allocation_table_core bidat_checker u_bidat_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .result_id   (result_id),
    .success     (success),
    .status_read (status_read),
    .in_use      (in_use)
);
